// ===== sv/arp_pkg.sv =====
// Shared types and constants of the atlas rectangle placer.
`default_nettype none

package arp_pkg;

    localparam int REQ_W  = 11;   // request size fields
    localparam int CFG_W  = 11;   // atlas size registers
    localparam int OUT_W  = 10;   // result coordinates
    localparam int SIDE_W = 12;   // pixel arithmetic, holds up to 4095

    localparam logic [CFG_W-1:0] CFG_SIDE_RESET = 11'd1024;

    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_DIV,
        S_CHK,
        S_YRD,
        S_CAND,
        S_ATT,
        S_WRD,
        S_WCHK,
        S_FIN,
        S_URD,
        S_UWR,
        S_RESP
    } arp_state_t;

    typedef struct packed {
        logic load_item;
        logic clear_store;
        logic div_step;
        logic y_init;
        logic rd_y;
        logic cand_load;
        logic att_next;
        logic win_init;
        logic rd_win;
        logic win_step;
        logic best_update;
        logic upd_init;
        logic rd_upd;
        logic upd_write;
        logic upd_step;
        logic out_load;
    } arp_cmd_t;

    typedef struct packed {
        logic op_clear;
        logic div_last;
        logic size_bad;
        logic y_done;
        logic cand_ok;
        logic att_last;
        logic conflict;
        logic win_last;
        logic found;
        logic upd_last;
        logic out_free;
    } arp_sts_t;

endpackage

`default_nettype wire

// ===== sv/arp_chan_if.sv =====
// Request and response channel interfaces of the atlas rectangle placer.
`default_nettype none

interface arp_in_if;
    import arp_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [REQ_W-1:0] req_width;
    logic [REQ_W-1:0] req_height;

    modport source (output valid, output op, output req_width, output req_height,
                    input ready);
    modport sink   (input valid, input op, input req_width, input req_height,
                    output ready);
endinterface

interface arp_out_if;
    import arp_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [OUT_W-1:0] dest_x;
    logic [OUT_W-1:0] dest_y;

    modport source (output valid, output found, output dest_x, output dest_y,
                    input ready);
    modport sink   (input valid, input found, input dest_x, input dest_y,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/atlas_rectangle_placer_top.sv =====
// Top level of the atlas rectangle placer: sequencer plus datapath.
//
//  channel   dir  transfer on          payload
//  req_ch    in   valid & ready        op, req_width, req_height
//  rsp_ch    out  valid & ready        found, dest_x, dest_y
//  cfg       in   cfg_we               cfg_index, cfg_data
//
// An allocate scans the rows, checks the window of each candidate and,
// when placed, writes the span of every covered row; the window check
// reads one span row at a time from the single-port span store.
// A clear and a rejected size skip the scan.
// Reset empties the span store at once through per-row valid bits.
// One item is in work at a time; a finished result waits in the output
// register and the next request is taken meanwhile.
`default_nettype none

module atlas_rectangle_placer_top
    import arp_pkg::*;
#(
    parameter int GRID_CELL = 8,
    parameter int MAX_SIDE  = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    arp_in_if.sink                req_ch,
    arp_out_if.source             rsp_ch,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    arp_cmd_t cmd;
    arp_sts_t sts;

    arp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    arp_dp #(
        .GRID_CELL (GRID_CELL),
        .MAX_SIDE  (MAX_SIDE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_op     (req_ch.op),
        .req_width  (req_ch.req_width),
        .req_height (req_ch.req_height),
        .out_ready  (rsp_ch.ready),
        .out_valid  (rsp_ch.valid),
        .out_found  (rsp_ch.found),
        .out_dest_x (rsp_ch.dest_x),
        .out_dest_y (rsp_ch.dest_y),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

`default_nettype wire

// ===== sv/arp_ctrl.sv =====
// Sequencer of the atlas rectangle placer: scan, window check and span update.
`default_nettype none

module arp_ctrl
    import arp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire arp_sts_t sts,
    output arp_cmd_t      cmd
);

    arp_state_t state_reg;
    arp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.op_clear)
                begin
                    cmd.clear_store = 1'b1;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.size_bad)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.y_init = 1'b1;
                    state_next = S_YRD;
                end
            end
            S_YRD:
            begin
                if (sts.y_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_y   = 1'b1;
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                cmd.cand_load = 1'b1;
                state_next    = S_ATT;
            end
            S_ATT:
            begin
                if (sts.cand_ok)
                begin
                    cmd.win_init = 1'b1;
                    state_next   = S_WRD;
                end
                else
                begin
                    cmd.att_next = 1'b1;
                    state_next   = sts.att_last ? S_YRD : S_ATT;
                end
            end
            S_WRD:
            begin
                cmd.rd_win = 1'b1;
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                if (sts.conflict)
                begin
                    cmd.att_next = 1'b1;
                    state_next   = sts.att_last ? S_YRD : S_ATT;
                end
                else if (sts.win_last)
                begin
                    cmd.best_update = 1'b1;
                    cmd.att_next    = 1'b1;
                    state_next      = sts.att_last ? S_YRD : S_ATT;
                end
                else
                begin
                    cmd.win_step = 1'b1;
                    state_next   = S_WRD;
                end
            end
            S_FIN:
            begin
                if (sts.found)
                begin
                    cmd.upd_init = 1'b1;
                    state_next   = S_URD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_URD:
            begin
                cmd.rd_upd = 1'b1;
                state_next = S_UWR;
            end
            S_UWR:
            begin
                cmd.upd_write = 1'b1;
                if (sts.upd_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.upd_step = 1'b1;
                    state_next   = S_URD;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/arp_dp.sv =====
// Datapath of the atlas rectangle placer: span store, cell counts, candidate and window logic.
`default_nettype none

module arp_dp
    import arp_pkg::*;
#(
    parameter int GRID_CELL = 8,
    parameter int MAX_SIDE  = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             req_op,
    input  wire logic [REQ_W-1:0] req_width,
    input  wire logic [REQ_W-1:0] req_height,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic                  out_found,
    output logic [OUT_W-1:0]      out_dest_x,
    output logic [OUT_W-1:0]      out_dest_y,
    input  wire arp_cmd_t         cmd,
    output arp_sts_t              sts
);

    localparam int NCELLS = MAX_SIDE / GRID_CELL;
    localparam int ROW_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CNT_W  = $clog2(NCELLS + 2);
    localparam int SPAN_W = $clog2(NCELLS + 1);
    localparam int DIV_W  = SIDE_W;
    localparam int RCP_SH = DIV_W + $clog2(GRID_CELL) + 1;
    localparam int RCP_W  = RCP_SH + 1;
    localparam int QP_W   = DIV_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SH) + 64'(GRID_CELL - 1)) / 64'(GRID_CELL));
    localparam int PROD_W = CNT_W + 11;
    localparam int NLANE  = 4;

    // configuration
    logic [CFG_W-1:0]  aw_reg;
    logic [CFG_W-1:0]  ah_reg;
    logic [SIDE_W-1:0] aw_eff;
    logic [SIDE_W-1:0] ah_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= CFG_SIDE_RESET;
            ah_reg <= CFG_SIDE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ATLAS_WIDTH)
            begin
                aw_reg <= cfg_data;
            end
            if (cfg_index == REG_ATLAS_HEIGHT)
            begin
                ah_reg <= cfg_data;
            end
        end
    end

    assign aw_eff = (SIDE_W'(aw_reg) > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                          : SIDE_W'(aw_reg);
    assign ah_eff = (SIDE_W'(ah_reg) > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                          : SIDE_W'(ah_reg);

    // item
    logic             op_reg;
    logic [REQ_W-1:0] w_reg;
    logic [REQ_W-1:0] h_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= req_op;
            w_reg  <= req_width;
            h_reg  <= req_height;
        end
    end

    // cell counts by reciprocal multiplication, four lanes: ceil w, ceil h, floor aw, floor ah
    logic [DIV_W-1:0] num_reg [NLANE];
    logic [QP_W-1:0]  qprod   [NLANE];

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            qprod[i] = QP_W'(num_reg[i]) * QP_W'(RCP_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            num_reg[0] <= SIDE_W'(req_width) + SIDE_W'(GRID_CELL - 1);
            num_reg[1] <= SIDE_W'(req_height) + SIDE_W'(GRID_CELL - 1);
            num_reg[2] <= aw_eff;
            num_reg[3] <= ah_eff;
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < NLANE; i++)
            begin
                num_reg[i] <= qprod[i][RCP_SH +: DIV_W];
            end
        end
    end

    logic [CNT_W-1:0] cw;
    logic [CNT_W-1:0] ch;
    logic [CNT_W-1:0] cols;
    logic [CNT_W-1:0] rows;

    // only used once the size check has passed, so the cell counts fit
    assign cw   = CNT_W'(num_reg[0]);
    assign ch   = CNT_W'(num_reg[1]);
    assign cols = CNT_W'(num_reg[2]);
    assign rows = CNT_W'(num_reg[3]);

    // span store; valid bits make an unwritten or cleared row read as empty
    logic [SPAN_W-1:0] mem_l [NCELLS];
    logic [SPAN_W-1:0] mem_r [NCELLS];
    logic [NCELLS-1:0] vld_reg;
    logic [SPAN_W-1:0] rl_q;
    logic [SPAN_W-1:0] rr_q;
    logic              vq_q;
    logic [ROW_W-1:0]  addr;
    logic              rd_en;
    logic [SPAN_W-1:0] ul;
    logic [SPAN_W-1:0] ur;

    logic [CNT_W-1:0] y_reg;
    logic             att_reg;
    logic [CNT_W-1:0] r_reg;
    logic [CNT_W-1:0] wend_reg;
    logic [CNT_W-1:0] cx_reg  [2];
    logic             cok_reg [2];
    logic             found_reg;
    logic [CNT_W-1:0] bx_reg;
    logic [CNT_W-1:0] by_reg;

    assign addr  = cmd.rd_y ? y_reg[ROW_W-1:0] : r_reg[ROW_W-1:0];
    assign rd_en = cmd.rd_y | cmd.rd_win | cmd.rd_upd;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rl_q <= mem_l[addr];
            rr_q <= mem_r[addr];
            vq_q <= vld_reg[addr];
        end
        if (cmd.upd_write)
        begin
            mem_l[addr] <= ul;
            mem_r[addr] <= ur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.clear_store)
        begin
            vld_reg <= '0;
        end
        else if (cmd.upd_write)
        begin
            vld_reg[addr] <= 1'b1;
        end
    end

    logic [CNT_W-1:0] sl;
    logic [CNT_W-1:0] sr;

    assign sl = vq_q ? CNT_W'(rl_q) : '0;
    assign sr = vq_q ? CNT_W'(rr_q) : '0;

    // candidate columns from the row just read
    logic [CNT_W:0]   cw1;
    logic [CNT_W:0]   x0;
    logic [CNT_W:0]   x1;
    logic             ok0;
    logic             ok1;

    assign cw1 = (CNT_W+1)'(cw) + 1'b1;
    assign x0  = (CNT_W+1)'(sl) - cw1;
    assign x1  = (sr == '0) ? '0 : (CNT_W+1)'(sr) + 1'b1;
    assign ok0 = ((CNT_W+1)'(sl) >= cw1)
                 && ((CNT_W+2)'(x0) + (CNT_W+2)'(cw) <= (CNT_W+2)'(cols));
    assign ok1 = (CNT_W+2)'(x1) + (CNT_W+2)'(cw) <= (CNT_W+2)'(cols);

    logic [CNT_W-1:0] xa;
    logic [CNT_W:0]   ych;
    logic [CNT_W-1:0] rows_m1;
    logic [CNT_W-1:0] wend;

    assign xa      = cx_reg[att_reg];
    assign ych     = (CNT_W+1)'(y_reg) + (CNT_W+1)'(ch);
    assign rows_m1 = rows - 1'b1;
    assign wend    = (ych > (CNT_W+1)'(rows_m1)) ? rows_m1 : CNT_W'(ych);

    // update values for the covered rows
    logic [CNT_W:0] bxe;

    assign bxe = (CNT_W+1)'(bx_reg) + (CNT_W+1)'(cw);

    always_comb
    begin
        if (vq_q && (rr_q != '0))
        begin
            ul = (CNT_W'(rl_q) > bx_reg) ? SPAN_W'(bx_reg) : rl_q;
            ur = ((CNT_W+1)'(rr_q) < bxe) ? SPAN_W'(bxe) : rr_q;
        end
        else
        begin
            ul = SPAN_W'(bx_reg);
            ur = SPAN_W'(bxe);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            att_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.best_update)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.y_init)
            begin
                att_reg <= 1'b0;
            end
            else if (cmd.att_next)
            begin
                att_reg <= ~att_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.y_init)
        begin
            y_reg <= '0;
        end
        else if (cmd.att_next && att_reg)
        begin
            y_reg <= y_reg + 1'b1;
        end
        if (cmd.cand_load)
        begin
            cx_reg[0]  <= CNT_W'(x0);
            cx_reg[1]  <= CNT_W'(x1);
            cok_reg[0] <= ok0;
            cok_reg[1] <= ok1;
        end
        if (cmd.win_init)
        begin
            r_reg    <= (y_reg == '0) ? '0 : y_reg - 1'b1;
            wend_reg <= wend;
        end
        else if (cmd.upd_init)
        begin
            r_reg <= by_reg;
        end
        else if (cmd.win_step || cmd.upd_step)
        begin
            r_reg <= r_reg + 1'b1;
        end
        if (cmd.best_update)
        begin
            bx_reg <= xa;
            by_reg <= y_reg;
        end
    end

    // result register
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [OUT_W-1:0] out_x_reg;
    logic [OUT_W-1:0] out_y_reg;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;

    assign prod_x = PROD_W'(bx_reg) * PROD_W'(GRID_CELL);
    assign prod_y = PROD_W'(by_reg) * PROD_W'(GRID_CELL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg <= found_reg;
            out_x_reg     <= found_reg ? prod_x[OUT_W-1:0] : '0;
            out_y_reg     <= found_reg ? prod_y[OUT_W-1:0] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_dest_x = out_x_reg;
    assign out_dest_y = out_y_reg;

    // status
    always_comb
    begin
        sts          = '0;
        sts.op_clear = (op_reg == OP_CLEAR);
        sts.div_last = 1'b1;
        sts.size_bad = (w_reg == '0) || (SIDE_W'(w_reg) > aw_eff)
                       || (h_reg == '0) || (SIDE_W'(h_reg) > ah_eff);
        sts.y_done   = ych > (CNT_W+1)'(rows);
        sts.cand_ok  = cok_reg[att_reg] && (!found_reg || (xa < bx_reg));
        sts.att_last = att_reg;
        sts.conflict = (sr != '0)
                       && ((CNT_W+2)'(sr) + 1'b1 > (CNT_W+2)'(xa))
                       && ((CNT_W+2)'(xa) + (CNT_W+2)'(cw) + 1'b1 > (CNT_W+2)'(sl));
        sts.win_last = (r_reg == wend_reg);
        sts.found    = found_reg;
        sts.upd_last = ((CNT_W+1)'(r_reg) + 1'b1)
                       == ((CNT_W+1)'(by_reg) + (CNT_W+1)'(ch));
        sts.out_free = !out_valid_reg || out_ready;
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_store |=> (vld_reg == '0))
        else $error("span store not empty after clear");

    a_best_improves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.best_update |-> (!found_reg || (xa < bx_reg)))
        else $error("best position replaced by one that is not further left");

    a_update_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_write |-> (found_reg
            && ((CNT_W+1)'(r_reg) < (CNT_W+1)'(by_reg) + (CNT_W+1)'(ch))))
        else $error("span written outside the placed band");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !found_reg) |=> (out_x_reg == '0 && out_y_reg == '0))
        else $error("failed placement carries a nonzero position");

endmodule

`default_nettype wire

// ===== tb/atlas_rectangle_placer_top_test.sv =====
// Self-checking testbench of the atlas rectangle placer: request driver, result monitor, predictor.
`timescale 1ns / 1ps

module atlas_rectangle_placer_top_test;
    import arp_pkg::*;

    localparam int    CELL      = 8;
    localparam int    SIDE_MAX  = 1024;
    localparam int    ROWS      = SIDE_MAX / CELL;
    localparam longint LIMIT    = 150_000_000;
    localparam int    SETTLE    = 40;
    localparam int    MAX_LINES = 40;

    typedef struct packed {
        logic             op;
        logic [REQ_W-1:0] w;
        logic [REQ_W-1:0] h;
    } request_t;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] dest_x;
        logic [OUT_W-1:0] dest_y;
    } placement_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    arp_in_if  req_ch ();
    arp_out_if rsp_ch ();

    atlas_rectangle_placer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state: atlas size and per-row occupied cell span [lo, hi)
    logic [CFG_W-1:0] atlas_w;
    logic [CFG_W-1:0] atlas_h;
    logic [7:0]       span_lo [ROWS];
    logic [7:0]       span_hi [ROWS];

    request_t   pending_reqs [$];
    placement_t awaited_places [$];
    request_t   next_req;
    placement_t want;

    int     send_idle_pct = 0;
    int     rsp_stall_pct = 0;
    int     err_cnt = 0;
    int     result_cnt = 0;
    int     req_cnt = 0;
    int     clear_cnt = 0;
    int     placed_cnt = 0;
    int     setting_cnt = 1;
    longint cycle_cnt = 0;

    // true if rows y-1 .. y+ch keep a one-cell gap to columns [x, x+cw)
    function automatic bit gap_is_clear(input int x, input int y, input int cw,
                                        input int ch, input int rows);
        int r;
        for (r = y - 1; r <= y + ch; r++)
        begin
            if (r < 0 || r >= rows)
                continue;
            if (span_hi[r] != 0 && int'(span_hi[r]) + 1 > x && x + cw + 1 > int'(span_lo[r]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic placement_t place_request(input logic op, input logic [REQ_W-1:0] w,
                                                 input logic [REQ_W-1:0] h);
        placement_t res;
        int aw, ah, cols, rows, iw, ih, cw, ch, bx, by, x, y, a, r;
        res = '0;
        aw = (int'(atlas_w) > SIDE_MAX) ? SIDE_MAX : int'(atlas_w);
        ah = (int'(atlas_h) > SIDE_MAX) ? SIDE_MAX : int'(atlas_h);
        cols = aw / CELL;
        rows = ah / CELL;
        iw = int'(w);
        ih = int'(h);
        if (op == OP_CLEAR)
        begin
            for (r = 0; r < ROWS; r++)
            begin
                span_lo[r] = '0;
                span_hi[r] = '0;
            end
            return res;
        end
        if (iw == 0 || iw > aw || ih == 0 || ih > ah)
            return res;
        cw = (iw + CELL - 1) / CELL;
        ch = (ih + CELL - 1) / CELL;
        bx = -1;
        by = 0;
        for (y = 0; y + ch <= rows; y++)
        begin
            for (a = 0; a < 2; a++)
            begin
                if (a == 0)
                    x = int'(span_lo[y]) - cw - 1;
                else
                begin
                    x = int'(span_hi[y]);
                    if (x != 0)
                        x++;
                end
                if (x < 0 || x + cw > cols)
                    continue;
                if (!gap_is_clear(x, y, cw, ch, rows))
                    continue;
                if (bx < 0 || x < bx)
                begin
                    bx = x;
                    by = y;
                end
            end
        end
        if (bx < 0)
            return res;
        for (r = by; r < by + ch && r < rows; r++)
        begin
            if (span_hi[r] != 0)
            begin
                if (int'(span_lo[r]) > bx)
                    span_lo[r] = 8'(bx);
                if (int'(span_hi[r]) < bx + cw)
                    span_hi[r] = 8'(bx + cw);
            end
            else
            begin
                span_lo[r] = 8'(bx);
                span_hi[r] = 8'(bx + cw);
            end
        end
        res.found  = 1'b1;
        res.dest_x = OUT_W'(bx * CELL);
        res.dest_y = OUT_W'(by * CELL);
        return res;
    endfunction

    // mostly small sides, some up to the atlas, a few zero or oversize
    function automatic logic [REQ_W-1:0] pick_side(input int lim);
        int unsigned sel;
        int narrow, mid;
        sel = $urandom_range(99);
        narrow = (lim < 24) ? lim : 24;
        mid = (lim < 96) ? lim : 96;
        if (sel < 3)
            return '0;
        else if (sel < 7)
            return REQ_W'($urandom_range(2047, lim + 1));
        else if (sel < 10)
            return REQ_W'(lim);
        else if (sel < 60)
            return REQ_W'($urandom_range(narrow, 1));
        else if (sel < 88)
            return REQ_W'($urandom_range(mid, 1));
        return REQ_W'($urandom_range(lim, 1));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        if (err_cnt < MAX_LINES)
            $display("[%0t] MISMATCH result %0d %s: got %0d, expected %0d",
                     $realtime, result_cnt, what, got, exp_val);
        err_cnt++;
    endtask

    task automatic queue_req(input logic op, input int w, input int h);
        request_t rq;
        rq.op = op;
        rq.w = REQ_W'(w);
        rq.h = REQ_W'(h);
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || awaited_places.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_atlas(input int w, input int h);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ATLAS_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= REG_ATLAS_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        cfg_we    <= 1'b0;
        atlas_w = CFG_W'(w);
        atlas_h = CFG_W'(h);
        setting_cnt++;
    endtask

    task automatic run_phase(input int aw, input int ah, input int send_pct,
                             input int stall_pct, input int n_items);
        int lw, lh, i;
        request_t rq;
        wait_drained();
        set_atlas(aw, ah);
        @(negedge clk);
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        lw = (aw > SIDE_MAX) ? SIDE_MAX : aw;
        lh = (ah > SIDE_MAX) ? SIDE_MAX : ah;
        for (i = 0; i < n_items; i++)
        begin
            rq.op = ($urandom_range(99) < 3) ? OP_CLEAR : OP_ALLOC;
            rq.w  = pick_side(lw);
            rq.h  = pick_side(lh);
            pending_reqs.push_back(rq);
        end
    endtask

    // request driver: a new item goes out once the previous transfer is done
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.op         <= OP_ALLOC;
            req_ch.req_width  <= '0;
            req_ch.req_height <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_places.push_back(place_request(req_ch.op, req_ch.req_width,
                                                       req_ch.req_height));
                req_cnt++;
                if (req_ch.op == OP_CLEAR)
                    clear_cnt++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.op         <= next_req.op;
                    req_ch.req_width  <= next_req.w;
                    req_ch.req_height <= next_req.h;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_places.size() == 0)
                    report_mismatch("unexpected transfer, found", rsp_ch.found, 0);
                else
                begin
                    want = awaited_places.pop_front();
                    if (rsp_ch.found !== want.found)
                        report_mismatch("found", rsp_ch.found, want.found);
                    if (rsp_ch.dest_x !== want.dest_x)
                        report_mismatch("dest_x", rsp_ch.dest_x, want.dest_x);
                    if (rsp_ch.dest_y !== want.dest_y)
                        report_mismatch("dest_y", rsp_ch.dest_y, want.dest_y);
                    if (want.found)
                        placed_cnt++;
                end
                result_cnt++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[%0t] timeout after %0d cycles, %0d results outstanding",
                 $realtime, cycle_cnt, awaited_places.size());
        $display("atlas_rectangle_placer_top verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_ALLOC;
        req_ch.req_width  = '0;
        req_ch.req_height = '0;
        rsp_ch.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_ATLAS_WIDTH;
        cfg_data          = '0;
        atlas_w           = CFG_SIDE_RESET;
        atlas_h           = CFG_SIDE_RESET;
        for (r = 0; r < ROWS; r++)
        begin
            span_lo[r] = '0;
            span_hi[r] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed, reset atlas size: bad sizes, rounding, full sides, atlas full
        @(negedge clk);
        queue_req(OP_CLEAR, 0, 0);
        queue_req(OP_ALLOC, 0, 8);
        queue_req(OP_ALLOC, 8, 0);
        queue_req(OP_ALLOC, 1025, 8);
        queue_req(OP_ALLOC, 8, 1025);
        queue_req(OP_ALLOC, 2047, 2047);
        queue_req(OP_ALLOC, 1, 1);
        queue_req(OP_ALLOC, 8, 8);
        queue_req(OP_ALLOC, 9, 17);
        queue_req(OP_ALLOC, 1024, 8);
        queue_req(OP_ALLOC, 8, 1024);
        queue_req(OP_CLEAR, 2047, 2047);
        queue_req(OP_ALLOC, 1024, 1024);
        queue_req(OP_ALLOC, 1, 1);
        queue_req(OP_CLEAR, 0, 0);
        queue_req(OP_ALLOC, 1023, 1023);

        // width not a cell multiple, height saturating above the store
        wait_drained();
        set_atlas(1020, 2047);
        @(negedge clk);
        queue_req(OP_CLEAR, 0, 0);
        queue_req(OP_ALLOC, 1020, 8);
        queue_req(OP_ALLOC, 1016, 8);
        queue_req(OP_ALLOC, 1021, 8);
        queue_req(OP_ALLOC, 8, 1024);
        queue_req(OP_CLEAR, 0, 0);
        queue_req(OP_ALLOC, 8, 1024);
        queue_req(OP_ALLOC, 8, 1025);

        run_phase(1024, 1024, 0, 0, 340);
        run_phase(256, 128, 63, 0, 300);
        run_phase(8, 8, 0, 63, 60);
        run_phase(64, 1024, 34, 34, 250);
        run_phase(1024, 64, 0, 0, 250);
        run_phase(2047, 13, 63, 0, 150);
        run_phase(200, 300, 0, 63, 250);
        run_phase(512, 512, 34, 34, 250);
        run_phase(5, 1024, 34, 34, 30);

        wait_drained();
        repeat (50) @(posedge clk);
        $display("%0d requests (%0d clears) over %0d atlas sizes, %0d results checked",
                 req_cnt, clear_cnt, setting_cnt, result_cnt);
        $display("%0d rectangles placed, %0d refused, %0d mismatches",
                 placed_cnt, result_cnt - placed_cnt - clear_cnt, err_cnt);
        if (err_cnt == 0 && awaited_places.size() == 0)
            $display("atlas_rectangle_placer_top verification clean");
        else
            $display("atlas_rectangle_placer_top verification failed");
        $finish;
    end

endmodule
